[sv/i2c_mss_pkg.sv]
// shared types, codes and constants of the i2c master status sequencer
package i2c_mss_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int QUEUE_AW         = 1;
    localparam int QUEUE_DEPTH      = 2 ** QUEUE_AW;

    // controller status codes
    localparam logic [7:0] ST_START_SENT   = 8'h08;
    localparam logic [7:0] ST_RESTART_SENT = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

    // configuration register indexes
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_OFFSET     = 2'd1;
    localparam logic [1:0] REG_LENGTH     = 2'd2;
    localparam logic [1:0] REG_DIRECTION  = 2'd3;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_STATUS = 2'd1,
        FUNC_BUF_WR = 2'd2,
        FUNC_BUF_RD = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_SI       = 3'd2,
        CMD_SI_ACK   = 3'd3,
        CMD_RESTART  = 3'd4,
        CMD_STOP     = 3'd5,
        CMD_CLR_TMO  = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_TIMEOUT,
        OP_STATUS,
        OP_BUF_WR,
        OP_BUF_RD
    } op_kind_t;

    typedef enum logic [2:0] {
        SK_START_SENT,
        SK_RESTART_SENT,
        SK_ADDR_W_ACK,
        SK_DATA_W_ACK,
        SK_ADDR_R_ACK,
        SK_DATA_R_ACK,
        SK_OTHER
    } stat_kind_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] bus_status;
        logic       timeout_seen;
        logic [7:0] rx_byte;
        logic [7:0] buf_index;
        logic [7:0] buf_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0] command;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [7:0] read_byte;
    } out_item_t;

    typedef struct packed {
        logic [7:0] slave_addr;
        logic [7:0] buffer_offset;
        logic [7:0] transfer_length;
        logic       direction;
    } cfg_t;

    // classified item as it travels from front to back
    typedef struct packed {
        op_kind_t   kind;
        stat_kind_t stat;
        logic [7:0] rx_byte;
        logic [7:0] buf_index;
        logic [7:0] buf_data;
    } op_t;

endpackage

[sv/i2c_mss_front.sv]
// front end: classifies an incoming transfer into an operation
module i2c_mss_front (
    input  i2c_mss_pkg::in_item_t item,
    output i2c_mss_pkg::op_t      op
);
    import i2c_mss_pkg::*;

    always_comb begin
        op.rx_byte   = item.rx_byte;
        op.buf_index = item.buf_index;
        op.buf_data  = item.buf_data;
        case (item.bus_status)
            ST_START_SENT:   op.stat = SK_START_SENT;
            ST_RESTART_SENT: op.stat = SK_RESTART_SENT;
            ST_ADDR_W_ACK:   op.stat = SK_ADDR_W_ACK;
            ST_DATA_W_ACK:   op.stat = SK_DATA_W_ACK;
            ST_ADDR_R_ACK:   op.stat = SK_ADDR_R_ACK;
            ST_DATA_R_ACK:   op.stat = SK_DATA_R_ACK;
            // data nack, address nack and unknown codes all end in stop
            default:         op.stat = SK_OTHER;
        endcase
        case (func_t'(item.func))
            FUNC_START:  op.kind = OP_START;
            FUNC_STATUS: op.kind = item.timeout_seen ? OP_TIMEOUT : OP_STATUS;
            FUNC_BUF_WR: op.kind = OP_BUF_WR;
            FUNC_BUF_RD: op.kind = OP_BUF_RD;
            default:     op.kind = OP_BUF_RD;
        endcase
    end

endmodule

[sv/i2c_mss_queue.sv]
// short queue of classified operations between front and back
module i2c_mss_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  i2c_mss_pkg::op_t     push_op,
    output logic                 full,
    output logic                 not_empty,
    input  logic                 pop,
    output i2c_mss_pkg::op_t     head_op
);
    import i2c_mss_pkg::*;

    op_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[sv/i2c_mss_back.sv]
// back end: sequencer state, data buffer and registered result stage
module i2c_mss_back #(
    parameter int BUFFER_DEPTH = i2c_mss_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  i2c_mss_pkg::cfg_t      cfg,
    input  logic                   op_valid,
    input  i2c_mss_pkg::op_t       op,
    output logic                   op_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output i2c_mss_pkg::out_item_t m_data
);
    import i2c_mss_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    logic [7:0]        buf_mem [BUFFER_DEPTH];
    logic [7:0]        mem_q_reg;

    logic [7:0]        byte_count_reg, byte_count_next;
    logic              end_flag_reg, end_flag_next;
    logic              armed_reg, armed_next;

    logic              out_valid_reg;
    cmd_t              cmd_reg, cmd_next;
    logic              txv_reg, txv_next;
    logic [7:0]        tx_byte_reg, tx_byte_next;
    logic              tx_mem_reg, tx_mem_next;
    logic              rd_mem_reg, rd_mem_next;
    logic              done_reg;

    logic [8:0]        pos_sum;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_rd, mem_wr;
    logic [7:0]        mem_wdata;
    logic [7:0]        count_inc;

    assign op_pop    = op_valid && (!out_valid_reg || m_ready);
    assign pos_sum   = {1'b0, cfg.buffer_offset} + {1'b0, byte_count_reg};
    assign pos_addr  = pos_sum[ADDR_W-1:0];
    assign count_inc = byte_count_reg + 8'd1;

    always_comb begin
        byte_count_next = byte_count_reg;
        end_flag_next   = end_flag_reg;
        armed_next      = armed_reg;
        cmd_next        = CMD_NONE;
        txv_next        = 1'b0;
        tx_byte_next    = '0;
        tx_mem_next     = 1'b0;
        rd_mem_next     = 1'b0;
        mem_rd          = 1'b0;
        mem_wr          = 1'b0;
        mem_addr        = op.buf_index[ADDR_W-1:0];
        mem_wdata       = op.buf_data;
        case (op.kind)
            OP_START: begin
                end_flag_next = 1'b0;
                armed_next    = 1'b1;
                cmd_next      = CMD_START;
            end
            OP_TIMEOUT: begin
                cmd_next = CMD_CLR_TMO;
            end
            OP_STATUS: begin
                if (armed_reg) begin
                    cmd_next = CMD_STOP;
                    case (op.stat)
                        SK_START_SENT: begin
                            byte_count_next = '0;
                            txv_next        = 1'b1;
                            tx_byte_next    = cfg.slave_addr;
                            cmd_next        = CMD_SI;
                        end
                        SK_ADDR_W_ACK: begin
                            txv_next     = 1'b1;
                            tx_byte_next = cfg.buffer_offset;
                            cmd_next     = CMD_SI;
                        end
                        SK_DATA_W_ACK: begin
                            if (cfg.direction) begin
                                cmd_next = CMD_RESTART;
                            end else if (byte_count_reg < cfg.transfer_length) begin
                                // next payload byte comes from the buffer
                                mem_rd          = 1'b1;
                                mem_addr        = pos_addr;
                                txv_next        = 1'b1;
                                tx_mem_next     = 1'b1;
                                byte_count_next = count_inc;
                                cmd_next        = CMD_SI;
                            end
                        end
                        SK_RESTART_SENT: begin
                            if (cfg.direction) begin
                                txv_next     = 1'b1;
                                tx_byte_next = cfg.slave_addr + 8'd1;
                                cmd_next     = CMD_SI_ACK;
                            end
                        end
                        SK_ADDR_R_ACK: begin
                            if (cfg.direction) begin
                                cmd_next = CMD_SI_ACK;
                            end
                        end
                        SK_DATA_R_ACK: begin
                            if (cfg.direction) begin
                                mem_wr          = 1'b1;
                                mem_addr        = pos_addr;
                                mem_wdata       = op.rx_byte;
                                byte_count_next = count_inc;
                                // nack goes out after the last stored byte
                                cmd_next = (count_inc < cfg.transfer_length) ?
                                           CMD_SI_ACK : CMD_SI;
                            end
                        end
                        default: begin
                            cmd_next = CMD_STOP;
                        end
                    endcase
                    if (cmd_next == CMD_STOP) begin
                        end_flag_next = 1'b1;
                    end
                end
            end
            OP_BUF_WR: begin
                mem_wr = 1'b1;
            end
            OP_BUF_RD: begin
                mem_rd      = 1'b1;
                rd_mem_next = 1'b1;
            end
            default: begin
                cmd_next = CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            end_flag_reg   <= 1'b0;
            armed_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (op_pop) begin
                byte_count_reg <= byte_count_next;
                end_flag_reg   <= end_flag_next;
                armed_reg      <= armed_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_pop) begin
            cmd_reg     <= cmd_next;
            txv_reg     <= txv_next;
            tx_byte_reg <= tx_byte_next;
            tx_mem_reg  <= tx_mem_next;
            rd_mem_reg  <= rd_mem_next;
            done_reg    <= end_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_pop && mem_wr) begin
            buf_mem[mem_addr] <= mem_wdata;
        end
        if (op_pop && mem_rd) begin
            mem_q_reg <= buf_mem[mem_addr];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_data.command   = cmd_reg;
    assign m_data.tx_valid  = txv_reg;
    assign m_data.tx_byte   = tx_mem_reg ? mem_q_reg : tx_byte_reg;
    assign m_data.done_res  = done_reg;
    assign m_data.read_byte = rd_mem_reg ? mem_q_reg : 8'd0;

endmodule

[sv/i2c_master_status_sequencer.sv]
// top level of the i2c master status sequencer
//
// turns controller status codes into i2c master commands for a register-offset
// transfer. every input transfer (start, status event, host buffer write or
// read) gives exactly one result transfer. the front end classifies the item
// and pushes it into a two-entry queue; the back end takes one item per clock
// while the result stage is empty or being taken, updates the byte counter and
// end flag, accesses the data buffer (one read-or-write port) and loads the
// registered result stage. a new item can be accepted every cycle while the
// queue is not full. the buffer has no reset: reading an entry that was never
// written returns an unspecified byte. BUFFER_DEPTH must be a power
// of two, since buffer indexes wrap by dropping upper bits. configuration
// registers are written through cfg_wen/cfg_idx/cfg_data and must only change
// while no transfer is in flight.
module i2c_master_status_sequencer #(
    parameter int BUFFER_DEPTH = i2c_mss_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wen,
    input  logic [1:0]             cfg_idx,
    input  logic [7:0]             cfg_data,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  i2c_mss_pkg::in_item_t  s_data,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output i2c_mss_pkg::out_item_t m_data
);
    import i2c_mss_pkg::*;

    cfg_t cfg_reg;
    op_t  front_op;
    op_t  head_op;
    logic q_full;
    logic q_not_empty;
    logic q_pop;
    logic q_push;

    // configuration registers, read live by the back end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_idx)
                REG_SLAVE_ADDR: cfg_reg.slave_addr      <= cfg_data;
                REG_OFFSET:     cfg_reg.buffer_offset   <= cfg_data;
                REG_LENGTH:     cfg_reg.transfer_length <= cfg_data;
                REG_DIRECTION:  cfg_reg.direction       <= cfg_data[0];
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // accept while the queue has room, independent of the result side
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    i2c_mss_front u_front (
        .item (s_data),
        .op   (front_op)
    );

    i2c_mss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (front_op),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head_op   (head_op)
    );

    i2c_mss_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .op_valid (q_not_empty),
        .op       (head_op),
        .op_pop   (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // a start command always reports the transfer as not done
    a_start_clears_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.command == CMD_START) |-> !m_data.done_res)
        else $error("start result with done set");

    // every stop command reports the transfer as done
    a_stop_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.command == CMD_STOP) |-> m_data.done_res)
        else $error("stop result without done");

    // buffer read data only travels with results that carry no command
    a_read_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.command != CMD_NONE) |-> (m_data.read_byte == 8'd0))
        else $error("read data on a command result");

    // a byte to send always comes with an i2c serial interrupt clear
    a_tx_with_si: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_valid |->
            (m_data.command == CMD_SI) || (m_data.command == CMD_SI_ACK))
        else $error("tx byte without si command");

endmodule
